// ===== rtl/chm_pkg.sv =====
// Shared types and codes of the chained hash map.
`default_nettype none
package chm_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REPLACE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_DELETE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXISTS  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int unsigned CountBits = 11;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [63:0]          value_out;
    logic [CountBits-1:0] element_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/chm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chm_front.sv =====
// Front end: accept requests, mask the key and work out the bucket index.
`default_nettype none
module chm_front import chm_pkg::*; #(
  parameter int unsigned BUCKETS  = 1024,
  parameter int unsigned KEY_BITS = 64,
  localparam int unsigned BW      = $clog2(BUCKETS),
  localparam int unsigned QW      = $bits(req_t) + BW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire req_t          in_req_i,
  output logic               push_o,
  input  wire logic          full_i,
  output logic [QW-1:0]      push_data_o
);

  localparam int unsigned RW       = BW + 1;
  localparam bit          POW2     = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [3:0]  MOD_STEPS = POW2 ? 4'd0 : 4'd8;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [RW-1:0] BUCKETS_R = RW'(BUCKETS);

  logic          stg_valid_q, stg_valid_d;
  req_t          stg_req_q;
  logic [3:0]    cnt_q, cnt_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [31:0]   sh_q, sh_d;
  logic [BW-1:0] bucket;
  logic          accept;

  assign in_ready_o = !stg_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = stg_valid_q && (cnt_q == 4'd0) && !full_i;
  assign bucket     = POW2 ? stg_req_q.key[BW-1:0] : rem_q[BW-1:0];
  assign push_data_o = {stg_req_q, bucket};

  // Reduce the low key word four bits a cycle, most significant first
  always_comb begin
    logic [RW-1:0] r;
    logic [31:0]   s;
    r = rem_q;
    s = sh_q;
    for (int i = 0; i < 4; i++) begin
      r = {r[RW-2:0], s[31]};
      s = {s[30:0], 1'b0};
      if (r >= BUCKETS_R) begin
        r = r - BUCKETS_R;
      end
    end
    rem_d       = rem_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    stg_valid_d = stg_valid_q;
    if (accept) begin
      rem_d       = '0;
      sh_d        = in_req_i.key[31:0] & KEY_MASK[31:0];
      cnt_d       = MOD_STEPS;
      stg_valid_d = 1'b1;
    end else if (stg_valid_q && cnt_q != 4'd0) begin
      rem_d = r;
      sh_d  = s;
      cnt_d = cnt_q - 4'd1;
    end else if (push_o) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (accept) begin
      stg_req_q.command <= in_req_i.command;
      stg_req_q.key     <= in_req_i.key & KEY_MASK;
      stg_req_q.value   <= in_req_i.value;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chm_queue.sv =====
// Two-entry queue between the front end and the chain walker.
`default_nettype none
module chm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;

  assign full_o     = fill_q == 2'd2;
  assign valid_o    = fill_q != 2'd0;
  assign pop_data_o = slot_q[rptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chm_back.sv =====
// Back end: walk the bucket chain, update the tables and drive the result.
`default_nettype none
module chm_back import chm_pkg::*; #(
  parameter int unsigned BUCKETS  = 1024,
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned KEY_BITS = 64,
  localparam int unsigned BW      = $clog2(BUCKETS),
  localparam int unsigned QW      = $bits(req_t) + BW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire logic [QW-1:0] q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rsp_t               out_rsp_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_HWT  = 11'b000_0000_0100,
    S_CHK  = 11'b000_0000_1000,
    S_CMP  = 11'b000_0001_0000,
    S_ACT  = 11'b000_0010_0000,
    S_FRD  = 11'b000_0100_0000,
    S_FWT  = 11'b000_1000_0000,
    S_INS  = 11'b001_0000_0000,
    S_DEL  = 11'b010_0000_0000,
    S_RESP = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  req_t          q_req;
  logic [BW-1:0] q_bucket;

  // Control registers
  logic [BW-1:0] clr_q, clr_d;
  logic [LW-1:0] rec_head_q, rec_head_d;
  logic [LW-1:0] fresh_q, fresh_d;
  logic [LW-1:0] total_q, total_d;
  logic          out_valid_q, out_valid_d;

  // Per-request working registers
  req_t          req_q, req_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic          hit_q, hit_d;
  logic [LW-1:0] hlink_q, hlink_d;
  logic [63:0]   hval_q, hval_d;
  logic [LW-1:0] ent_q, ent_d;
  logic [1:0]    status_q, status_d;
  logic [63:0]   vout_q, vout_d;
  rsp_t          rsp_q, rsp_d;

  // Memory ports
  logic          bh_we, bh_re;
  logic [BW-1:0] bh_waddr, bh_raddr;
  logic [LW-1:0] bh_wdata, bh_rdata;
  logic          ent_we, ent_re;
  logic [AW-1:0] ent_waddr, ent_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic [63:0]   val_rdata;
  logic          ln_we, ln_re;
  logic [AW-1:0] ln_waddr, ln_raddr;
  logic [LW-1:0] ln_wdata, ln_rdata;
  logic          val_we;
  logic [AW-1:0] val_waddr;

  assign q_req    = req_t'(q_data_i[QW-1:BW]);
  assign q_bucket = q_data_i[BW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i, .we_i(bh_we), .waddr_i(bh_waddr), .wdata_i(bh_wdata),
    .re_i(bh_re), .raddr_i(bh_raddr), .rdata_o(bh_rdata)
  );

  chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(req_q.key[KEY_BITS-1:0]),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(key_rdata)
  );

  chm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(req_q.value),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(val_rdata)
  );

  chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .re_i(ln_re), .raddr_i(ln_raddr), .rdata_o(ln_rdata)
  );

  // Sequence one request through lookup and update
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rec_head_d  = rec_head_q;
    fresh_d     = fresh_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    bkt_d       = bkt_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    hlink_d     = hlink_q;
    hval_d      = hval_q;
    ent_d       = ent_q;
    status_d    = status_q;
    vout_d      = vout_q;
    rsp_d       = rsp_q;
    q_pop_o     = 1'b0;
    bh_we       = 1'b0;
    bh_waddr    = bkt_q;
    bh_wdata    = ent_q;
    bh_re       = 1'b0;
    bh_raddr    = q_bucket;
    ent_re      = 1'b0;
    ent_raddr   = cur_q[AW-1:0];
    ent_we      = 1'b0;
    ent_waddr   = ent_q[AW-1:0];
    val_we      = 1'b0;
    val_waddr   = ent_q[AW-1:0];
    ln_we       = 1'b0;
    ln_waddr    = ent_q[AW-1:0];
    ln_wdata    = head_q;
    ln_re       = 1'b0;
    ln_raddr    = cur_q[AW-1:0];

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_q;
        bh_wdata = NIL;
        clr_d    = clr_q + BW'(1);
        if (clr_q == LAST_BUCKET) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          bh_re    = 1'b1;
          req_d    = q_req;
          bkt_d    = q_bucket;
          hit_d    = 1'b0;
          prev_d   = NIL;
          status_d = ST_OK;
          vout_d   = '0;
          state_d  = S_HWT;
        end
      end
      S_HWT: begin
        head_d  = bh_rdata;
        cur_d   = bh_rdata;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cur_q == NIL) begin
          state_d = S_ACT;
        end else begin
          ent_re  = 1'b1;
          ln_re   = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (key_rdata == req_q.key[KEY_BITS-1:0]) begin
          hit_d   = 1'b1;
          hlink_d = ln_rdata;
          hval_d  = val_rdata;
          state_d = S_ACT;
        end else begin
          prev_d  = cur_q;
          cur_d   = ln_rdata;
          state_d = S_CHK;
        end
      end
      S_ACT: begin
        state_d = S_RESP;
        priority if (req_q.command == CMD_INSERT || req_q.command == CMD_REPLACE) begin
          if (hit_q) begin
            if (req_q.command == CMD_INSERT) begin
              status_d = ST_EXISTS;
            end else begin
              val_we    = 1'b1;
              val_waddr = cur_q[AW-1:0];
            end
          end else if (rec_head_q != NIL) begin
            ent_d   = rec_head_q;
            state_d = S_FRD;
          end else if (fresh_q != NIL) begin
            ent_d   = fresh_q;
            fresh_d = fresh_q + LW'(1);
            state_d = S_INS;
          end else begin
            status_d = ST_FULL;
          end
        end else if (req_q.command == CMD_LOOKUP) begin
          if (hit_q) vout_d = hval_q;
          else       status_d = ST_MISSING;
        end else begin
          if (hit_q) begin
            if (prev_q != NIL) begin
              ln_we    = 1'b1;
              ln_waddr = prev_q[AW-1:0];
              ln_wdata = hlink_q;
            end else begin
              bh_we    = 1'b1;
              bh_wdata = hlink_q;
            end
            state_d = S_DEL;
          end else begin
            status_d = ST_MISSING;
          end
        end
      end
      S_FRD: begin
        ln_re    = 1'b1;
        ln_raddr = rec_head_q[AW-1:0];
        state_d  = S_FWT;
      end
      S_FWT: begin
        rec_head_d = ln_rdata;
        state_d    = S_INS;
      end
      S_INS: begin
        ent_we  = 1'b1;
        val_we  = 1'b1;
        ln_we   = 1'b1;
        bh_we   = 1'b1;
        total_d = total_q + LW'(1);
        state_d = S_RESP;
      end
      S_DEL: begin
        ln_we      = 1'b1;
        ln_waddr   = cur_q[AW-1:0];
        ln_wdata   = rec_head_q;
        rec_head_d = cur_q;
        if (total_q != '0) total_d = total_q - LW'(1);
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          rsp_d.status        = status_q;
          rsp_d.value_out     = vout_q;
          rsp_d.element_count = CountBits'(total_q);
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      rec_head_q  <= NIL;
      fresh_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rec_head_q  <= rec_head_d;
      fresh_q     <= fresh_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_d_hold: begin
      req_q    <= req_d;
      bkt_q    <= bkt_d;
      head_q   <= head_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      hit_q    <= hit_d;
      hlink_q  <= hlink_d;
      hval_q   <= hval_d;
      ent_q    <= ent_d;
      status_q <= status_d;
      vout_q   <= vout_d;
      rsp_q    <= rsp_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chained_hash_map_top.sv =====
// Top level of the chained hash map.
`default_nettype none
// Key-value map with separate chaining over a fixed pool of ENTRIES entries and
// BUCKETS chain heads. After reset the block clears the bucket-head memory,
// one bucket a cycle. Up to three requests are taken in during the clear and
// held in the front end and queue until it completes. A request passes the
// front-end staging register and the queue before it reaches the chain walker.
// For each chain entry visited the walker reads the key and link memories in
// S_CHK, a registered read, and compares the key in S_CMP. S_ACT then acts on
// the command; a delete goes on to S_DEL, an insert from unused entries to
// S_INS, and an insert that reuses a deleted entry reads the free list in S_FRD
// and S_FWT before S_INS. The result is registered in S_RESP and held until
// taken. When BUCKETS is not a power of two the front end reduces the low key
// word to a bucket index, overlapped with the walk of the previous request
// through a two-entry queue. Exactly one result is returned per request.
module chained_hash_map_top import chm_pkg::*; #(
  parameter int unsigned BUCKETS  = 1024,
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned QW = $bits(req_t) + BW;

  logic          push, full, q_valid, pop;
  logic [QW-1:0] push_data, pop_data;

  chm_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .push_o(push), .full_i(full), .push_data_o(push_data)
  );

  chm_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .pop_data_o(pop_data)
  );

  chm_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(pop_data), .q_pop_o(pop),
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

endmodule
`default_nettype wire

// ===== rtl/chm_checker.sv =====
// Port-level checker for the chained hash map and its bind.
`default_nettype none
module chm_checker import chm_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_rsp_o
);

  logic [3:0]           pend_q;
  logic                 seen_q;
  logic [CountBits-1:0] last_cnt_q;
  logic                 in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track requests in flight and the last reported count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else begin
      pend_q <= pend_q + {3'b0, in_acc} - {3'b0, out_acc};
      if (out_acc) begin
        seen_q     <= 1'b1;
        last_cnt_q <= out_rsp_o.element_count;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd5)
    else $error("too many requests in flight");

  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q &&
    (out_rsp_o.status == ST_EXISTS || out_rsp_o.status == ST_MISSING)
    |-> out_rsp_o.element_count == last_cnt_q)
    else $error("count changed on a failed request");

endmodule

bind chained_hash_map_top chm_checker u_chm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_rsp_o
);
`default_nettype wire
